/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL modules.
// Each macro expands to one labeled concurrent assertion that is
// clocked on the rising edge and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: lbl");

// When the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: lbl");

`endif

/* hw/rtl/qsp_pkg.sv */
`timescale 1ns / 1ps

package qsp_pkg;

   // Special characters of the query string.
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_EQ      = 8'h3D;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   // Result kinds.
   localparam logic [1:0] KIND_KEY     = 2'd0;
   localparam logic [1:0] KIND_VAL     = 2'd1;
   localparam logic [1:0] KIND_END_KEY = 2'd2;
   localparam logic [1:0] KIND_END_VAL = 2'd3;

   // Escape progress codes.
   localparam logic [1:0] PEND_NONE    = 2'd0;
   localparam logic [1:0] PEND_PERCENT = 2'd1;
   localparam logic [1:0] PEND_DIGIT   = 2'd2;

   // One input byte causes at most this many result beats.
   localparam int MAX_RESULTS = 6;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       qend;
   } entry_type;

   typedef struct packed {
      entry_type [MAX_RESULTS-1:0] entries;
      logic [CNT_W-1:0]            count;
   } list_type;

   typedef struct packed {
      logic       value_field;
      logic [1:0] pending_count;
      logic [7:0] pending_char;
   } state_type;

   // True for 0-9, A-F and a-f.
   function automatic logic is_hex(input logic [7:0] b);
      return ((b >= 8'h30) && (b <= 8'h39)) ||
             ((b >= 8'h41) && (b <= 8'h46)) ||
             ((b >= 8'h61) && (b <= 8'h66));
   endfunction

   // Nibble value of a hex digit; a non-hex byte gives zero.
   function automatic logic [3:0] hex_value(input logic [7:0] b);
      logic [7:0] v;
      v = 8'h00;
      if ((b >= 8'h30) && (b <= 8'h39)) begin
         v = b - 8'h30;
      end else if ((b >= 8'h41) && (b <= 8'h46)) begin
         v = b - 8'h37;
      end else if ((b >= 8'h61) && (b <= 8'h66)) begin
         v = b - 8'h57;
      end
      return v[3:0];
   endfunction

   // Append one result to a list; a full list drops it.
   function automatic list_type push(input list_type l, input logic [1:0] kind,
                                     input logic [7:0] data, input logic qend);
      list_type r;
      r = l;
      if (r.count < CNT_W'(MAX_RESULTS)) begin
         r.entries[r.count].kind = kind;
         r.entries[r.count].data = data;
         r.entries[r.count].qend = qend;
         r.count = r.count + CNT_W'(1);
      end
      return r;
   endfunction

endpackage

/* hw/rtl/query_string_parser_decoder.sv */
`timescale 1ns / 1ps
// Query string splitter and percent decoder.
// The req_ channel takes one raw byte per beat, with req_final_byte set on
// the last byte of a string. The rsp_ channel gives one decoded result per
// beat: a key or value byte, an end-of-key or an end-of-value marker.
// rsp_run_last marks the last result caused by one input byte, and
// rsp_query_end marks the end-of-value marker that closes the string.
// An accepted byte is held in the input register, decoded straight from it
// and written into a result buffer of up to six entries once the buffer is
// free; its results are then shown on rsp_ from that buffer.
// The buffer drains one result per cycle while rsp_stall is low, and a byte
// that yields several results keeps the next input byte waiting in the input
// register until the last of them leaves. Bytes that only open or extend an
// escape yield no result.
// When the receiver stalls, the current result holds and the input stalls
// once the input register is full. Reset is synchronous and active high;
// it empties both registers and returns the parser to the key field with
// no escape open.
`include "assert_macros.svh"

module query_string_parser_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_query_end
);

   localparam int CntW = qsp_pkg::CNT_W;

   logic                in_vld_ff, in_vld_in;
   logic [7:0]          in_byte_ff, in_byte_in;
   logic                in_final_ff, in_final_in;
   qsp_pkg::state_type  state_ff, state_in, state_dec;
   qsp_pkg::list_type   list_ff, list_in, list_dec;
   logic [CntW-1:0]     idx_ff, idx_in;
   qsp_pkg::entry_type  cur_entry;
   logic                rsp_beat;
   logic                buf_free;
   logic                xfer;
   logic                req_beat;

   qsp_decode u_decode (
      .in_byte    (in_byte_ff),
      .final_byte (in_final_ff),
      .state_cur  (state_ff),
      .state_nxt  (state_dec),
      .results    (list_dec)
   );

   // Result buffer read side.
   assign rsp_valid = idx_ff < list_ff.count;
   assign rsp_beat  = rsp_valid && !rsp_stall;
   assign cur_entry = rsp_valid ? list_ff.entries[idx_ff] : '0;

   assign rsp_kind      = cur_entry.kind;
   assign rsp_out_byte  = cur_entry.data;
   assign rsp_query_end = cur_entry.qend;
   assign rsp_run_last  = rsp_valid && (idx_ff == (list_ff.count - CntW'(1)));

   // The buffer takes a new list once its last result leaves.
   assign buf_free  = !rsp_valid || (rsp_beat && rsp_run_last);
   assign xfer      = in_vld_ff && buf_free;
   assign req_stall = in_vld_ff && !buf_free;
   assign req_beat  = req_valid && !req_stall;

   always_comb begin
      in_vld_in   = in_vld_ff;
      in_byte_in  = in_byte_ff;
      in_final_in = in_final_ff;
      if (req_beat) begin
         in_vld_in   = 1'b1;
         in_byte_in  = req_in_byte;
         in_final_in = req_final_byte;
      end else if (xfer) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      list_in  = list_ff;
      idx_in   = idx_ff;
      if (xfer) begin
         state_in = state_dec;
         list_in  = list_dec;
         idx_in   = '0;
      end else if (rsp_beat) begin
         idx_in = idx_ff + CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff      <= in_byte_in;
      in_final_ff     <= in_final_in;
      list_ff.entries <= list_in.entries;
      if (reset) begin
         in_vld_ff     <= 1'b0;
         state_ff      <= '0;
         list_ff.count <= '0;
         idx_ff        <= '0;
      end else begin
         in_vld_ff     <= in_vld_in;
         state_ff      <= state_in;
         list_ff.count <= list_in.count;
         idx_ff        <= idx_in;
      end
   end

   // The string end comes only as the last end-of-value result of its byte.
   `ASSERT_ALWAYS(a_qend_marker, clock, reset,
      !(rsp_valid && rsp_query_end) ||
      ((rsp_kind == qsp_pkg::KIND_END_VAL) && rsp_run_last))
   // Decoding a final byte leaves the parser in its reset state.
   `ASSERT_NEXT(a_final_clears, clock, reset, xfer && in_final_ff,
      (state_ff.value_field == 1'b0) &&
      (state_ff.pending_count == qsp_pkg::PEND_NONE))
   // The escape counter never reaches its unused code.
   `ASSERT_ALWAYS(a_pend_range, clock, reset, state_ff.pending_count != 2'd3)
   // The read index never runs past the stored results.
   `ASSERT_ALWAYS(a_idx_range, clock, reset, idx_ff <= list_ff.count)

endmodule

/* hw/rtl/qsp_decode.sv */
`timescale 1ns / 1ps

module qsp_decode (
   input  logic [7:0]          in_byte,
   input  logic                final_byte,
   input  qsp_pkg::state_type  state_cur,
   output qsp_pkg::state_type  state_nxt,
   output qsp_pkg::list_type   results
);

   qsp_pkg::state_type st;
   qsp_pkg::list_type  l;
   logic               consumed;
   logic               hex_ok;
   logic [1:0]         data_kind;

   always_comb begin
      st        = state_cur;
      l         = '0;
      consumed  = 1'b0;
      hex_ok    = qsp_pkg::is_hex(in_byte);
      data_kind = state_cur.value_field ? qsp_pkg::KIND_VAL : qsp_pkg::KIND_KEY;

      // Continue an open escape, or emit it literally when it breaks.
      if (st.pending_count == qsp_pkg::PEND_PERCENT) begin
         if (hex_ok) begin
            st.pending_char  = in_byte;
            st.pending_count = qsp_pkg::PEND_DIGIT;
            consumed         = 1'b1;
         end else begin
            l = qsp_pkg::push(l, data_kind, qsp_pkg::CH_PERCENT, 1'b0);
            st.pending_count = qsp_pkg::PEND_NONE;
            st.pending_char  = 8'h00;
         end
      end else if (st.pending_count != qsp_pkg::PEND_NONE) begin
         if (hex_ok) begin
            l = qsp_pkg::push(l, data_kind,
                              {qsp_pkg::hex_value(st.pending_char),
                               qsp_pkg::hex_value(in_byte)}, 1'b0);
            consumed = 1'b1;
         end else begin
            l = qsp_pkg::push(l, data_kind, qsp_pkg::CH_PERCENT, 1'b0);
            l = qsp_pkg::push(l, data_kind, st.pending_char, 1'b0);
         end
         st.pending_count = qsp_pkg::PEND_NONE;
         st.pending_char  = 8'h00;
      end

      // Handle the byte as a fresh character.
      if (!consumed) begin
         if (in_byte == qsp_pkg::CH_PERCENT) begin
            st.pending_count = qsp_pkg::PEND_PERCENT;
            st.pending_char  = 8'h00;
         end else if (in_byte == qsp_pkg::CH_PLUS) begin
            l = qsp_pkg::push(l, data_kind, qsp_pkg::CH_SPACE, 1'b0);
         end else if (in_byte == qsp_pkg::CH_AMP) begin
            if (!st.value_field) begin
               l = qsp_pkg::push(l, qsp_pkg::KIND_END_KEY, 8'h00, 1'b0);
            end
            l = qsp_pkg::push(l, qsp_pkg::KIND_END_VAL, 8'h00, 1'b0);
            st.value_field = 1'b0;
         end else if ((in_byte == qsp_pkg::CH_EQ) && !st.value_field) begin
            l = qsp_pkg::push(l, qsp_pkg::KIND_END_KEY, 8'h00, 1'b0);
            st.value_field = 1'b1;
         end else begin
            l = qsp_pkg::push(l, data_kind, in_byte, 1'b0);
         end
      end

      // The final byte closes the open pair and returns to the reset state.
      if (final_byte) begin
         if (st.pending_count != qsp_pkg::PEND_NONE) begin
            l = qsp_pkg::push(l, st.value_field ? qsp_pkg::KIND_VAL : qsp_pkg::KIND_KEY,
                              qsp_pkg::CH_PERCENT, 1'b0);
         end
         if ((st.pending_count != qsp_pkg::PEND_NONE) &&
             (st.pending_count != qsp_pkg::PEND_PERCENT)) begin
            l = qsp_pkg::push(l, st.value_field ? qsp_pkg::KIND_VAL : qsp_pkg::KIND_KEY,
                              st.pending_char, 1'b0);
         end
         if (!st.value_field) begin
            l = qsp_pkg::push(l, qsp_pkg::KIND_END_KEY, 8'h00, 1'b0);
         end
         l  = qsp_pkg::push(l, qsp_pkg::KIND_END_VAL, 8'h00, 1'b1);
         st = '0;
      end
   end

   assign state_nxt = st;
   assign results   = l;

endmodule
